FILE: design/tme_pkg.sv
package tme_pkg;

   // field widths
   localparam int unsigned OP_W    = 4;
   localparam int unsigned ARG_W   = 16;
   localparam int unsigned PC_W    = 16;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned PTR_W   = 15;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   // tape geometry, set by the pointer width
   localparam int unsigned TAPE_SIZE = 1 << PTR_W;

   // program counter wraps at the pc width
   localparam int unsigned PROGRAM_DEPTH = 1 << PC_W;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PROGRAM_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SINGLE_STEP    = 2'd1;

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_NOP        = 4'd0,
      OP_ADD        = 4'd1,
      OP_MOVE       = 4'd2,
      OP_JUMP       = 4'd3,
      OP_JUMP_NZ    = 4'd4,
      OP_READ       = 4'd5,
      OP_WRITE      = 4'd6,
      OP_BREAKPOINT = 4'd7,
      OP_SET_CELL   = 4'd8,
      OP_EXIT       = 4'd9
   } op_type;

   // stop reasons
   typedef enum logic [2:0] {
      STOP_RUN     = 3'd0,
      STOP_BREAK   = 3'd1,
      STOP_OS_INT  = 3'd2,
      STOP_UNKNOWN = 3'd3,
      STOP_EXIT    = 3'd4,
      STOP_EOP     = 3'd5,
      STOP_STEP    = 3'd6
   } stop_type;

   // one result word
   typedef struct packed {
      logic [PC_W-1:0]    next_pc;
      logic               output_valid;
      logic [BYTE_W-1:0]  output_byte;
      logic [BYTE_W-1:0]  current_cell;
      logic [PTR_W-1:0]   pointer_position;
      stop_type           stop_reason;
      logic [COUNT_W-1:0] executed_count;
   } rsp_type;

endpackage

FILE: design/tape_machine_execute_unit.sv
// Tape machine execute unit: takes one decoded instruction word per cycle on the req_
// channel and presents its result word on the rsp_ channel through the execute stage
// and output registers. The 32768-byte tape lives in a single synchronous RAM with one
// write and one read port; the cell under the pointer is held in a register, so add, read
// and set-cell write it straight back, and only a move reads the RAM, at the new pointer,
// whose data is forwarded to the next word and merged into the result as it enters the
// output register. Sustained rate is one word per cycle while rsp_ready stays high. After
// reset the RAM is cleared one entry per cycle, during which req_ready is low; csr writes
// are taken at all times and must only be made while no word is in flight.
module tape_machine_execute_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [tme_pkg::OP_W-1:0]        req_operation,
   input  logic signed [tme_pkg::ARG_W-1:0] req_argument,
   input  logic [tme_pkg::PC_W-1:0]        req_destination,
   input  logic [tme_pkg::BYTE_W-1:0]      req_input_byte,
   input  logic                            req_input_at_end,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [tme_pkg::PC_W-1:0]        rsp_next_pc,
   output logic                            rsp_output_valid,
   output logic [tme_pkg::BYTE_W-1:0]      rsp_output_byte,
   output logic [tme_pkg::BYTE_W-1:0]      rsp_current_cell,
   output logic [tme_pkg::PTR_W-1:0]       rsp_pointer_position,
   output logic [2:0]                      rsp_stop_reason,
   output logic [tme_pkg::COUNT_W-1:0]     rsp_executed_count,
   input  logic                            csr_write_enable,
   input  logic [tme_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tme_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import tme_pkg::*;

   // tape storage
   logic [BYTE_W-1:0] tape_mem [TAPE_SIZE];
   logic [BYTE_W-1:0] rd_data_ff;

   // machine state
   logic [PC_W-1:0]    pc_ff, pc_in;
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               eoi_ff, eoi_in;
   logic               halted_ff, halted_in;
   logic [BYTE_W-1:0]  cell_ff, cell_in;

   // configuration
   logic [PC_W-1:0] len_ff;
   logic            step_ff;

   // clearing pass
   logic             clr_busy_ff;
   logic [PTR_W-1:0] clr_addr_ff;

   // execute and output stages
   rsp_type d_ff, d_in;
   logic    d_valid_ff, d_mem_ff;
   rsp_type o_ff, o_in;
   logic    o_valid_ff;

   logic              accept, d_adv, exec, is_move, cell_wr;
   logic [BYTE_W-1:0] cur_cell, cell_new, out_byte;
   logic              out_valid, brk, osint, halt_set, count_en;
   stop_type          halt_code, reason;
   op_type            op;
   logic [PC_W-1:0]   pc_new;
   logic [PTR_W-1:0]  ptr_new;
   logic              mem_we;
   logic [PTR_W-1:0]  mem_waddr;
   logic [BYTE_W-1:0] mem_wdata;

   // handshake and stage movement
   assign d_adv     = d_valid_ff && (!o_valid_ff || rsp_ready);
   assign req_ready = !clr_busy_ff && (!d_valid_ff || d_adv);
   assign accept    = req_valid && req_ready;

   // cell under the pointer, forwarded from the ram after a move
   assign cur_cell = (d_valid_ff && d_mem_ff) ? rd_data_ff : cell_ff;

   assign op   = op_type'(req_operation);
   assign exec = !halted_ff && (pc_ff < len_ff);

   // instruction decode and execute
   always_comb begin
      pc_new    = pc_ff + PC_W'(1);
      ptr_new   = ptr_ff;
      cell_new  = cur_cell;
      cell_wr   = 1'b0;
      is_move   = 1'b0;
      count_en  = 1'b0;
      eoi_in    = eoi_ff;
      brk       = 1'b0;
      osint     = 1'b0;
      halt_set  = 1'b0;
      halt_code = STOP_RUN;
      out_valid = 1'b0;
      out_byte  = '0;
      case (op)
         OP_NOP: begin
            count_en = 1'b1;
         end
         OP_ADD: begin
            count_en = 1'b1;
            cell_new = cur_cell + req_argument[BYTE_W-1:0];
            cell_wr  = 1'b1;
         end
         OP_MOVE: begin
            count_en = 1'b1;
            ptr_new  = ptr_ff + req_argument[PTR_W-1:0];
            is_move  = 1'b1;
         end
         OP_JUMP: begin
            count_en = 1'b1;
            pc_new   = req_destination;
         end
         OP_JUMP_NZ: begin
            count_en = 1'b1;
            if (cur_cell != '0) begin
               pc_new = req_destination;
            end
         end
         OP_READ: begin
            count_en = 1'b1;
            if (req_input_at_end) begin
               osint  = eoi_ff;
               eoi_in = 1'b1;
            end else begin
               cell_new = req_input_byte;
               cell_wr  = 1'b1;
            end
         end
         OP_WRITE: begin
            count_en  = 1'b1;
            out_valid = 1'b1;
            out_byte  = cur_cell;
         end
         OP_BREAKPOINT: begin
            brk    = 1'b1;
            pc_new = pc_ff;
         end
         OP_SET_CELL: begin
            count_en = 1'b1;
            cell_new = req_argument[BYTE_W-1:0];
            cell_wr  = 1'b1;
         end
         OP_EXIT: begin
            halt_set  = 1'b1;
            halt_code = STOP_EXIT;
         end
         default: begin
            halt_set  = 1'b1;
            halt_code = STOP_UNKNOWN;
         end
      endcase

      // stop priority
      if (!exec) begin
         reason = halted_ff ? STOP_UNKNOWN : STOP_EOP;
      end else if (brk) begin
         reason = STOP_BREAK;
      end else if (osint) begin
         reason = STOP_OS_INT;
      end else if (halt_set) begin
         reason = halt_code;
      end else if (step_ff) begin
         reason = STOP_STEP;
      end else if (pc_new >= len_ff) begin
         reason = STOP_EOP;
      end else begin
         reason = STOP_RUN;
      end

      // state update only for an executed word
      if (accept && exec) begin
         pc_in     = pc_new;
         ptr_in    = ptr_new;
         count_in  = count_ff + COUNT_W'(count_en);
         halted_in = halted_ff || halt_set;
         cell_in   = cell_new;
      end else begin
         pc_in     = pc_ff;
         ptr_in    = ptr_ff;
         count_in  = count_ff;
         halted_in = halted_ff;
         eoi_in    = eoi_ff;
         cell_in   = cur_cell;
      end

      // result word, current cell filled from the ram later for a move
      d_in.next_pc          = pc_in;
      d_in.output_valid     = exec && out_valid;
      d_in.output_byte      = exec ? out_byte : '0;
      d_in.current_cell     = cell_in;
      d_in.pointer_position = ptr_in;
      d_in.stop_reason      = reason;
      d_in.executed_count   = count_in;
   end

   // ram write port: clearing pass or write-back of the current cell
   assign mem_we    = clr_busy_ff || (accept && exec && cell_wr);
   assign mem_waddr = clr_busy_ff ? clr_addr_ff : ptr_ff;
   assign mem_wdata = clr_busy_ff ? '0 : cell_new;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tape_mem[mem_waddr] <= mem_wdata;
      end
      if (accept && exec && is_move) begin
         rd_data_ff <= tape_mem[ptr_new];
      end
   end

   // clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + PTR_W'(1);
         if (clr_addr_ff == PTR_W'(TAPE_SIZE - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         step_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PROGRAM_LENGTH: len_ff  <= csr_write_data[PC_W-1:0];
            CSR_SINGLE_STEP:    step_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // machine state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff     <= '0;
         ptr_ff    <= '0;
         count_ff  <= '0;
         eoi_ff    <= 1'b0;
         halted_ff <= 1'b0;
         cell_ff   <= '0;
      end else begin
         pc_ff     <= pc_in;
         ptr_ff    <= ptr_in;
         count_ff  <= count_in;
         eoi_ff    <= eoi_in;
         halted_ff <= halted_in;
         cell_ff   <= cell_in;
      end
   end

   // execute stage
   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         d_mem_ff   <= 1'b0;
      end else if (accept) begin
         d_valid_ff <= 1'b1;
         d_mem_ff   <= exec && is_move;
      end else if (d_adv) begin
         d_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         d_ff <= d_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (d_adv) begin
         o_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         o_valid_ff <= 1'b0;
      end
   end

   // result word with the cell read after a move merged in
   always_comb begin
      o_in = d_ff;
      if (d_mem_ff) begin
         o_in.current_cell = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (d_adv) begin
         o_ff <= o_in;
      end
   end

   assign rsp_valid            = o_valid_ff;
   assign rsp_next_pc          = o_ff.next_pc;
   assign rsp_output_valid     = o_ff.output_valid;
   assign rsp_output_byte      = o_ff.output_byte;
   assign rsp_current_cell     = o_ff.current_cell;
   assign rsp_pointer_position = o_ff.pointer_position;
   assign rsp_stop_reason      = o_ff.stop_reason;
   assign rsp_executed_count   = o_ff.executed_count;

endmodule

FILE: design/tme_checker.sv
module tme_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [tme_pkg::PC_W-1:0]        rsp_next_pc,
   input logic                            rsp_output_valid,
   input logic [tme_pkg::BYTE_W-1:0]      rsp_output_byte,
   input logic [tme_pkg::BYTE_W-1:0]      rsp_current_cell,
   input logic [2:0]                      rsp_stop_reason,
   input logic [tme_pkg::COUNT_W-1:0]     rsp_executed_count
);
   import tme_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_pc)
         && $stable(rsp_output_byte) && $stable(rsp_current_cell)
         && $stable(rsp_executed_count))
      else $error("result word changed while stalled");

   // no result word straight after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // tape clearing keeps the input closed after reset
   a_req_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("word accepted during tape clearing");

   // an output byte comes only from a write that ran to completion
   a_out_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_output_valid |->
         rsp_stop_reason == STOP_RUN || rsp_stop_reason == STOP_STEP
         || rsp_stop_reason == STOP_EOP)
      else $error("output byte with a stopping reason");

endmodule

bind tape_machine_execute_unit tme_checker u_tme_checker (.*);

FILE: verif/tape_machine_execute_unit_tb.sv
module tape_machine_execute_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tme_pkg::*;

   localparam int unsigned PHASE_ITEMS    = 160;
   localparam int unsigned RANDOM_PHASES  = 8;
   localparam int unsigned LOW_LENGTH     = 1200;
   localparam int unsigned MAX_LENGTH     = 65535;
   localparam int unsigned REPORT_LIMIT   = 40;
   localparam int unsigned TIMEOUT_CYCLES = 1000000;

   // one instruction word as the req_ channel carries it
   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [ARG_W-1:0]  argument;
      logic [PC_W-1:0]   destination;
      logic [BYTE_W-1:0] input_byte;
      logic              input_at_end;
   } instr_word_type;

   logic clock;
   logic reset = 1'b1;

   logic           req_valid = 1'b0;
   logic           req_ready;
   instr_word_type req_word  = '0;
   logic           rsp_valid;
   logic           rsp_ready = 1'b0;

   logic [PC_W-1:0]    rsp_next_pc;
   logic               rsp_output_valid;
   logic [BYTE_W-1:0]  rsp_output_byte;
   logic [BYTE_W-1:0]  rsp_current_cell;
   logic [PTR_W-1:0]   rsp_pointer_position;
   logic [2:0]         rsp_stop_reason;
   logic [COUNT_W-1:0] rsp_executed_count;

   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index        = '0;
   logic [CSR_DATA_W-1:0] csr_write_data   = '0;

   // words waiting to be sent and results waiting to come back
   instr_word_type instr_queue[$];
   rsp_type        pending_results[$];

   int unsigned words_sent      = 0;
   int unsigned words_accepted  = 0;
   int unsigned words_checked   = 0;
   int unsigned csr_writes      = 0;
   int unsigned mismatch_count  = 0;
   int unsigned cycle_count     = 0;
   int unsigned send_gap        = 0;
   int unsigned stall_left      = 0;
   int unsigned reason_tally [8];
   bit          gaps_on         = 1'b1;

   // shadow copy of the machine
   logic [BYTE_W-1:0]  tape_shadow [TAPE_SIZE];
   logic [PTR_W-1:0]   mach_ptr;
   logic [PC_W-1:0]    mach_pc;
   logic [COUNT_W-1:0] mach_count;
   logic               mach_eof_seen;
   logic               mach_halted;
   logic [PC_W-1:0]    cfg_length;
   logic               cfg_single_step;

   tape_machine_execute_unit uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_operation        (req_word.operation),
      .req_argument         (req_word.argument),
      .req_destination      (req_word.destination),
      .req_input_byte       (req_word.input_byte),
      .req_input_at_end     (req_word.input_at_end),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_next_pc          (rsp_next_pc),
      .rsp_output_valid     (rsp_output_valid),
      .rsp_output_byte      (rsp_output_byte),
      .rsp_current_cell     (rsp_current_cell),
      .rsp_pointer_position (rsp_pointer_position),
      .rsp_stop_reason      (rsp_stop_reason),
      .rsp_executed_count   (rsp_executed_count),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // machine state after reset
   function automatic void clear_machine();
      for (int i = 0; i < TAPE_SIZE; i++) tape_shadow[i] = '0;
      mach_ptr        = '0;
      mach_pc         = '0;
      mach_count      = '0;
      mach_eof_seen   = 1'b0;
      mach_halted     = 1'b0;
      cfg_length      = '0;
      cfg_single_step = 1'b0;
   endfunction

   // execute one instruction on the shadow machine and give the state it reports
   function automatic rsp_type run_instruction(instr_word_type w);
      rsp_type          r;
      logic [PTR_W-1:0] at;
      logic             brk;
      logic             osint;
      logic             halting;
      stop_type         halt_code;
      r         = '0;
      brk       = 1'b0;
      osint     = 1'b0;
      halting   = 1'b0;
      halt_code = STOP_RUN;
      if (mach_halted) begin
         r.stop_reason = STOP_UNKNOWN;
      end else if (mach_pc >= cfg_length) begin
         r.stop_reason = STOP_EOP;
      end else begin
         at      = mach_ptr;
         mach_pc = mach_pc + 1'b1;
         if (w.operation <= OP_SET_CELL && w.operation != OP_BREAKPOINT)
            mach_count = mach_count + 1'b1;
         case (w.operation)
            OP_NOP: ;
            OP_ADD: tape_shadow[at] = tape_shadow[at] + w.argument[7:0];
            // pointer wraps at the tape size
            OP_MOVE: mach_ptr = PTR_W'(int'(at) + int'($signed(w.argument)));
            OP_JUMP: mach_pc = w.destination;
            OP_JUMP_NZ: begin
               if (tape_shadow[at] != '0) mach_pc = w.destination;
            end
            // a second end of input raises the os interrupt, a good byte never clears it
            OP_READ: begin
               if (w.input_at_end) begin
                  if (mach_eof_seen) osint = 1'b1;
                  mach_eof_seen = 1'b1;
               end else begin
                  tape_shadow[at] = w.input_byte;
               end
            end
            OP_WRITE: begin
               r.output_valid = 1'b1;
               r.output_byte  = tape_shadow[at];
            end
            OP_BREAKPOINT: begin
               brk     = 1'b1;
               mach_pc = mach_pc - 1'b1;
            end
            OP_SET_CELL: tape_shadow[at] = w.argument[7:0];
            OP_EXIT: begin
               mach_halted = 1'b1;
               halting     = 1'b1;
               halt_code   = STOP_EXIT;
            end
            default: begin
               mach_halted = 1'b1;
               halting     = 1'b1;
               halt_code   = STOP_UNKNOWN;
            end
         endcase
         // stop priority
         if (brk) r.stop_reason = STOP_BREAK;
         else if (osint) r.stop_reason = STOP_OS_INT;
         else if (halting) r.stop_reason = halt_code;
         else if (cfg_single_step) r.stop_reason = STOP_STEP;
         else if (mach_pc >= cfg_length) r.stop_reason = STOP_EOP;
         else r.stop_reason = STOP_RUN;
      end
      r.next_pc          = mach_pc;
      r.current_cell     = tape_shadow[mach_ptr];
      r.pointer_position = mach_ptr;
      r.executed_count   = mach_count;
      return r;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // a plausible program word with random content
   function automatic instr_word_type random_instr(int unsigned dest_hi);
      instr_word_type w;
      int unsigned    roll;
      w.operation    = OP_NOP;
      w.argument     = ARG_W'($urandom());
      w.destination  = PC_W'($urandom());
      w.input_byte   = BYTE_W'($urandom());
      w.input_at_end = ($urandom_range(0, 6) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         w.operation = OP_NOP;
      end else if (roll < 24) begin
         w.operation = OP_ADD;
      end else if (roll < 44) begin
         w.operation = OP_MOVE;
         // short strides keep revisiting cells written earlier
         if ($urandom_range(0, 4) != 0) w.argument = ARG_W'(int'($urandom_range(0, 6)) - 3);
      end else if (roll < 52) begin
         w.operation = OP_SET_CELL;
      end else if (roll < 64) begin
         w.operation = OP_WRITE;
      end else if (roll < 76) begin
         w.operation = OP_READ;
      end else if (roll < 82) begin
         w.operation   = OP_JUMP;
         w.destination = PC_W'($urandom_range(0, dest_hi));
      end else if (roll < 92) begin
         w.operation   = OP_JUMP_NZ;
         w.destination = PC_W'($urandom_range(0, dest_hi));
      end else begin
         w.operation = OP_BREAKPOINT;
      end
      return w;
   endfunction

   task automatic push_instr(input logic [OP_W-1:0] op, input logic [ARG_W-1:0] arg,
                             input logic [PC_W-1:0] dest, input logic [BYTE_W-1:0] data,
                             input logic at_end);
      instr_word_type w;
      w.operation    = op;
      w.argument     = arg;
      w.destination  = dest;
      w.input_byte   = data;
      w.input_at_end = at_end;
      instr_queue.push_back(w);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      csr_writes++;
   endtask

   // nothing queued, nothing in flight, nothing owed
   task automatic wait_idle();
      do @(negedge clock);
      while (instr_queue.size() != 0 || words_sent != words_accepted ||
             pending_results.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   task automatic flag_mismatch(input string what, input longint unsigned got,
                                input longint unsigned want);
      if (mismatch_count < REPORT_LIMIT)
         $display("word %0d: %s got %0h want %0h", words_checked, what, got, want);
      mismatch_count++;
   endtask

   // req_ driver: holds a word until taken, then an optional gap
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && words_sent != words_accepted) begin
         // word still waiting for ready
      end else if (send_gap != 0) begin
         req_valid <= 1'b0;
         send_gap  <= send_gap - 1;
      end else if (instr_queue.size() != 0) begin
         req_word  <= instr_queue.pop_front();
         req_valid <= 1'b1;
         words_sent = words_sent + 1;
         send_gap  <= gaps_on ? pick_gap() : 0;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // rsp_ back-pressure
   always @(negedge clock) begin
      if (!reset && stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!reset && gaps_on && $urandom_range(0, 3) == 0) stall_left <= 1 + pick_gap();
      end
   end

   // shadow update on accepted words and register writes, check of returned words
   always @(posedge clock) begin : scoreboard
      rsp_type want;
      if (reset) begin
         clear_machine();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_PROGRAM_LENGTH: cfg_length = csr_write_data[PC_W-1:0];
               CSR_SINGLE_STEP:    cfg_single_step = csr_write_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            pending_results.push_back(run_instruction(req_word));
            words_accepted = words_accepted + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               flag_mismatch("word with nothing expected, next_pc", rsp_next_pc, 0);
            end else begin
               want = pending_results.pop_front();
               reason_tally[want.stop_reason]++;
               if (rsp_next_pc != want.next_pc)
                  flag_mismatch("next_pc", rsp_next_pc, want.next_pc);
               if (rsp_output_valid != want.output_valid)
                  flag_mismatch("output_valid", rsp_output_valid, want.output_valid);
               if (rsp_output_byte != want.output_byte)
                  flag_mismatch("output_byte", rsp_output_byte, want.output_byte);
               if (rsp_current_cell != want.current_cell)
                  flag_mismatch("current_cell", rsp_current_cell, want.current_cell);
               if (rsp_pointer_position != want.pointer_position)
                  flag_mismatch("pointer_position", rsp_pointer_position,
                                want.pointer_position);
               if (rsp_stop_reason != want.stop_reason)
                  flag_mismatch("stop_reason", rsp_stop_reason, want.stop_reason);
               if (rsp_executed_count != want.executed_count)
                  flag_mismatch("executed_count", rsp_executed_count, want.executed_count);
            end
            words_checked++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == TIMEOUT_CYCLES) begin
         $display("run stopped after %0d cycles with %0d words owed", cycle_count,
                  pending_results.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // stimulus
   initial begin
      instr_word_type w;
      int unsigned    prog_len;
      int unsigned    low_len;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty program: nothing executes
      write_csr(CSR_PROGRAM_LENGTH, 0);
      write_csr(CSR_SINGLE_STEP, 0);
      push_instr(OP_NOP, 0, 0, 0, 0);
      push_instr(OP_ADD, 16'h0005, 0, 0, 0);

      // every operation but nop and exit, and the edges of the fields
      wait_idle();
      write_csr(CSR_PROGRAM_LENGTH, CSR_DATA_W'(MAX_LENGTH));
      push_instr(OP_ADD, 16'h7FFF, 0, 0, 0);
      push_instr(OP_WRITE, 0, 0, 0, 0);
      push_instr(OP_ADD, 16'h8000, 0, 0, 0);
      push_instr(OP_JUMP_NZ, 0, 16'd10, 0, 0);
      push_instr(OP_MOVE, 16'h7FFF, 0, 0, 0);
      push_instr(OP_SET_CELL, 16'h125A, 0, 0, 0);
      push_instr(OP_MOVE, 16'h0001, 0, 0, 0);
      push_instr(OP_MOVE, 16'h8000, 0, 0, 0);
      push_instr(OP_MOVE, 16'hFFFF, 0, 0, 0);
      push_instr(OP_WRITE, 0, 0, 0, 0);
      push_instr(OP_READ, 0, 0, 8'hA5, 0);
      push_instr(OP_READ, 0, 0, 8'hFF, 1);
      push_instr(OP_READ, 0, 0, 8'h3C, 1);
      push_instr(OP_READ, 0, 0, 8'h00, 0);
      push_instr(OP_JUMP_NZ, 0, 16'hFFFF, 0, 0);
      push_instr(OP_BREAKPOINT, 0, 0, 0, 0);
      push_instr(OP_JUMP, 0, 16'd3, 0, 0);

      // single step loses to breakpoint and os interrupt
      wait_idle();
      write_csr(CSR_SINGLE_STEP, 1);
      push_instr(OP_BREAKPOINT, 0, 0, 0, 0);
      push_instr(OP_READ, 0, 0, 8'h11, 1);
      push_instr(OP_ADD, 16'h0001, 0, 0, 0);

      // running off the end of the program
      wait_idle();
      write_csr(CSR_SINGLE_STEP, 0);
      write_csr(CSR_PROGRAM_LENGTH, CSR_DATA_W'(mach_pc + 2));
      push_instr(OP_NOP, 0, 0, 0, 0);
      push_instr(OP_NOP, 0, 0, 0, 0);
      push_instr(OP_NOP, 0, 0, 0, 0);

      // single step outranks end of program
      wait_idle();
      prog_len = mach_pc + 2;
      write_csr(CSR_SINGLE_STEP, 1);
      write_csr(CSR_PROGRAM_LENGTH, CSR_DATA_W'(prog_len));
      push_instr(OP_JUMP, 0, PC_W'(prog_len), 0, 0);
      push_instr(OP_NOP, 0, 0, 0, 0);

      // random programs; jump targets stay low enough that pc never reaches the end
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_idle();
         gaps_on <= (p % 3) != 2;
         low_len = mach_pc + 1;
         if (low_len < LOW_LENGTH) low_len = LOW_LENGTH;
         prog_len = (p == 0) ? MAX_LENGTH : $urandom_range(low_len, MAX_LENGTH);
         write_csr(CSR_PROGRAM_LENGTH, CSR_DATA_W'(prog_len));
         write_csr(CSR_SINGLE_STEP, CSR_DATA_W'($urandom_range(0, 3) == 0));
         push_instr(OP_JUMP, ARG_W'($urandom()), PC_W'($urandom_range(0, 1000)),
                    BYTE_W'($urandom()), 0);
         for (int i = 1; i < PHASE_ITEMS; i++)
            instr_queue.push_back(random_instr(prog_len - PHASE_ITEMS - 3));
      end

      // short program that random code runs out of
      wait_idle();
      gaps_on <= 1'b1;
      prog_len = mach_pc + $urandom_range(1, 20);
      write_csr(CSR_PROGRAM_LENGTH, CSR_DATA_W'(prog_len));
      write_csr(CSR_SINGLE_STEP, 0);
      for (int i = 0; i < 30; i++) instr_queue.push_back(random_instr(MAX_LENGTH - 1));

      // last of all the machine halts, and stays halted
      wait_idle();
      write_csr(CSR_PROGRAM_LENGTH, CSR_DATA_W'(MAX_LENGTH));
      push_instr(OP_JUMP, 0, PC_W'($urandom_range(0, 1000)), 0, 0);
      for (int i = 0; i < 10; i++) instr_queue.push_back(random_instr(1000));
      w = random_instr(1000);
      if ($urandom_range(0, 1) == 0) w.operation = OP_EXIT;
      else w.operation = OP_W'($urandom_range(10, 15));
      instr_queue.push_back(w);
      for (int i = 0; i < 20; i++) begin
         w = random_instr(MAX_LENGTH);
         w.operation = OP_W'($urandom_range(0, 15));
         instr_queue.push_back(w);
      end
      wait_idle();
      write_csr(CSR_SINGLE_STEP, 1);
      for (int i = 0; i < 3; i++) instr_queue.push_back(random_instr(MAX_LENGTH));

      wait_idle();
      repeat (8) @(negedge clock);
      $display("%0d words checked over %0d register writes, %0d mismatches",
               words_checked, csr_writes, mismatch_count);
      $display("stops: run %0d break %0d os-int %0d unknown %0d exit %0d end %0d step %0d",
               reason_tally[STOP_RUN], reason_tally[STOP_BREAK], reason_tally[STOP_OS_INT],
               reason_tally[STOP_UNKNOWN], reason_tally[STOP_EXIT], reason_tally[STOP_EOP],
               reason_tally[STOP_STEP]);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/tme_pkg.sv
design/tape_machine_execute_unit.sv
design/tme_checker.sv
verif/tape_machine_execute_unit_tb.sv
